[rtl/ced_pkg.sv]
// Shared codes, widths and types for the capped edit distance block.
`default_nettype none
package ced_pkg;
    localparam int ACT_W  = 2;
    localparam int SYM_W  = 8;
    localparam int DIST_W = 7;

    localparam logic [ACT_W-1:0] ACT_APPEND_FIRST  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_APPEND_SECOND = 2'd1;
    localparam logic [ACT_W-1:0] ACT_COMPARE       = 2'd2;

    localparam logic [DIST_W-1:0] TOO_LONG_CODE = 7'd99;

    typedef struct packed {
        logic              done;
        logic [DIST_W-1:0] distance;
    } t_sweep_out;
endpackage
`default_nettype wire

[rtl/ced_sym_store.sv]
// One symbol string store with its length counter and overflow flag.
`default_nettype none
module ced_sym_store
    import ced_pkg::*;
#(
    parameter int MAX_LEN = 24,
    localparam int LW = $clog2(MAX_LEN + 1),
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_append,
    input  wire logic [SYM_W-1:0] i_symbol,
    input  wire logic             i_clear,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [SYM_W-1:0] o_rd_data,
    output logic      [LW-1:0]    o_length,
    output logic                  o_overflow
);
    logic [SYM_W-1:0] r_mem [MAX_LEN];
    logic [SYM_W-1:0] r_rd_data;
    logic [LW-1:0]    r_length, n_length;
    logic             r_overflow, n_overflow;
    logic             full;

    assign full = (r_length == LW'(MAX_LEN));

    always_comb begin
        n_length   = r_length;
        n_overflow = r_overflow;
        if (i_clear) begin
            n_length   = '0;
            n_overflow = 1'b0;
        end else if (i_append) begin
            if (full) begin
                n_overflow = 1'b1;
            end else begin
                n_length = r_length + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length   <= '0;
            r_overflow <= 1'b0;
        end else begin
            r_length   <= n_length;
            r_overflow <= n_overflow;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_append && !full) begin
            r_mem[r_length[AW-1:0]] <= i_symbol;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data  = r_rd_data;
    assign o_length   = r_length;
    assign o_overflow = r_overflow;
endmodule
`default_nettype wire

[rtl/ced_sweep.sv]
// Dynamic program sequencer over one rolling row, with the row cost memory.
`default_nettype none
module ced_sweep
    import ced_pkg::*;
#(
    parameter int MAX_LEN = 24,
    localparam int LW = $clog2(MAX_LEN + 1),
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
    localparam int CW = $clog2(MAX_LEN + 2)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [LW-1:0]    i_n,
    input  wire logic [LW-1:0]    i_m,
    output logic      [AW-1:0]    o_addr_a,
    output logic      [AW-1:0]    o_addr_b,
    input  wire logic [SYM_W-1:0] i_sym_a,
    input  wire logic [SYM_W-1:0] i_sym_b,
    output logic                  o_busy,
    output t_sweep_out            o_result
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_CALC = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [LW-1:0] r_i, n_i, r_j, n_j, r_n, n_n, r_m, n_m;
    logic [CW-1:0] r_left, n_left, r_diag, n_diag;
    logic [CW-1:0] r_mem [MAX_LEN + 1];
    logic [CW-1:0] r_row_rd;
    logic [CW-1:0] up, best, cand_left, cand_diag;
    logic          row_wr;

    assign o_addr_a = AW'(r_i - 1'b1);
    assign o_addr_b = AW'(r_j - 1'b1);
    assign o_busy   = (r_state != ST_IDLE);

    always_comb begin
        up        = (r_i == LW'(1)) ? CW'(r_j) : r_row_rd;
        cand_left = r_left + 1'b1;
        cand_diag = r_diag + CW'(i_sym_a != i_sym_b);
        best      = up + 1'b1;
        if (cand_left < best) begin
            best = cand_left;
        end
        if (cand_diag < best) begin
            best = cand_diag;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_i      = r_i;
        n_j      = r_j;
        n_n      = r_n;
        n_m      = r_m;
        n_left   = r_left;
        n_diag   = r_diag;
        row_wr   = 1'b0;
        o_result = '{done: 1'b0, distance: DIST_W'(best)};
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_n     = i_n;
                    n_m     = i_m;
                    n_i     = LW'(1);
                    n_j     = LW'(1);
                    n_left  = CW'(1);
                    n_diag  = '0;
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_CALC;
            end
            ST_CALC: begin
                row_wr  = 1'b1;
                n_state = ST_READ;
                if (r_j == r_m) begin
                    if (r_i == r_n) begin
                        o_result.done = 1'b1;
                        n_state       = ST_IDLE;
                    end else begin
                        n_i    = r_i + 1'b1;
                        n_j    = LW'(1);
                        n_left = CW'(r_i) + 1'b1;
                        n_diag = CW'(r_i);
                    end
                end else begin
                    n_j    = r_j + 1'b1;
                    n_left = best;
                    n_diag = up;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i    <= n_i;
        r_j    <= n_j;
        r_n    <= n_n;
        r_m    <= n_m;
        r_left <= n_left;
        r_diag <= n_diag;
    end

    always_ff @(posedge i_clk) begin
        if (row_wr) begin
            r_mem[r_j] <= best;
        end
        r_row_rd <= r_mem[r_j];
    end
endmodule
`default_nettype wire

[rtl/capped_edit_distance_top.sv]
// Top level of the capped edit distance block: stores, sweep and result register.
`default_nettype none
// Append beats (action 0 or 1) are accepted while the sweep is idle, also
// while a result still waits on the output. A compare beat with an
// overflowed or empty string is answered in the next cycle. Otherwise the
// sweep visits every cell of the n by m table, each in a read state (memory
// read), then a calc state (update and write back of the row cost memory),
// and takes no further beat until done. A compare is held off while the
// previous result has not been taken. Action code 3 is accepted and ignored.
module capped_edit_distance_top
    import ced_pkg::*;
#(
    parameter int MAX_LEN = 24
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [ACT_W-1:0]  i_action,
    input  wire logic [SYM_W-1:0]  i_symbol,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic      [DIST_W-1:0] o_distance,
    output logic                   o_too_long
);
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    logic              accept, compare, sweep_busy, empty_pair, start;
    logic [LW-1:0]     len_a, len_b;
    logic              ovf_a, ovf_b;
    logic [AW-1:0]     addr_a, addr_b;
    logic [SYM_W-1:0]  sym_a, sym_b;
    t_sweep_out        sweep_res;
    logic              r_out_valid, n_out_valid;
    logic [DIST_W-1:0] r_distance, n_distance;
    logic              r_too_long, n_too_long;

    assign o_ready    = !sweep_busy && !((i_action == ACT_COMPARE) && r_out_valid);
    assign accept     = i_valid && o_ready;
    assign compare    = accept && (i_action == ACT_COMPARE);
    assign empty_pair = (len_a == '0) || (len_b == '0);
    assign start      = compare && !ovf_a && !ovf_b && !empty_pair;

    ced_sym_store #(.MAX_LEN(MAX_LEN)) u_store_a (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_append   (accept && (i_action == ACT_APPEND_FIRST)),
        .i_symbol   (i_symbol),
        .i_clear    (compare),
        .i_rd_addr  (addr_a),
        .o_rd_data  (sym_a),
        .o_length   (len_a),
        .o_overflow (ovf_a)
    );

    ced_sym_store #(.MAX_LEN(MAX_LEN)) u_store_b (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_append   (accept && (i_action == ACT_APPEND_SECOND)),
        .i_symbol   (i_symbol),
        .i_clear    (compare),
        .i_rd_addr  (addr_b),
        .o_rd_data  (sym_b),
        .o_length   (len_b),
        .o_overflow (ovf_b)
    );

    ced_sweep #(.MAX_LEN(MAX_LEN)) u_sweep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_n      (len_a),
        .i_m      (len_b),
        .o_addr_a (addr_a),
        .o_addr_b (addr_b),
        .i_sym_a  (sym_a),
        .i_sym_b  (sym_b),
        .o_busy   (sweep_busy),
        .o_result (sweep_res)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        n_distance  = r_distance;
        n_too_long  = r_too_long;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        if (compare && (ovf_a || ovf_b)) begin
            n_out_valid = 1'b1;
            n_distance  = TOO_LONG_CODE;
            n_too_long  = 1'b1;
        end else if (compare && empty_pair) begin
            n_out_valid = 1'b1;
            n_distance  = (len_a == '0) ? DIST_W'(len_b) : DIST_W'(len_a);
            n_too_long  = 1'b0;
        end else if (sweep_res.done) begin
            n_out_valid = 1'b1;
            n_distance  = sweep_res.distance;
            n_too_long  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_distance <= n_distance;
        r_too_long <= n_too_long;
    end

    assign o_valid    = r_out_valid;
    assign o_distance = r_distance;
    assign o_too_long = r_too_long;
endmodule
`default_nettype wire

[rtl/ced_checker.sv]
// Port-level checker for the capped edit distance block and its bind.
`default_nettype none
module ced_checker
    import ced_pkg::*;
#(
    parameter int MAX_LEN = 24
) (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_valid,
    input wire logic              o_ready,
    input wire logic [ACT_W-1:0]  i_action,
    input wire logic              o_valid,
    input wire logic              i_ready,
    input wire logic [DIST_W-1:0] o_distance,
    input wire logic              o_too_long
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_distance) && $stable(o_too_long))
        else $error("result beat changed while stalled");

    a_sentinel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_too_long |-> o_distance == TOO_LONG_CODE)
        else $error("too_long without sentinel distance");

    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_too_long |-> o_distance <= DIST_W'(MAX_LEN))
        else $error("distance beyond maximum string length");

    a_cmp_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_action == ACT_COMPARE) |-> !o_valid)
        else $error("compare beat taken while result pending");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat present after reset");
endmodule

bind capped_edit_distance_top ced_checker #(.MAX_LEN(MAX_LEN)) u_ced_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_ready    (o_ready),
    .i_action   (i_action),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_distance (o_distance),
    .o_too_long (o_too_long)
);
`default_nettype wire

[tb/ced_checker.sv]
// Scoreboard for the capped edit distance block: tracks both channels, predicts and compares.
module ced_scoreboard
    import ced_pkg::*;
#(
    parameter int MAX_LEN     = 24,
    parameter int MAX_REPORTS = 10
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_ready,
    input  wire logic [ACT_W-1:0]  i_action,
    input  wire logic [SYM_W-1:0]  i_symbol,
    input  wire logic              i_out_valid,
    input  wire logic              i_out_ready,
    input  wire logic [DIST_W-1:0] i_distance,
    input  wire logic              i_too_long,
    output int                     o_fail_count,
    output int                     o_pending
);

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              too_long;
    } t_ced_result;

    t_ced_result      awaited_distances[$];
    logic [SYM_W-1:0] first_syms [MAX_LEN];
    logic [SYM_W-1:0] second_syms [MAX_LEN];
    int               first_len    = 0;
    int               second_len   = 0;
    bit               first_ovf    = 1'b0;
    bit               second_ovf   = 1'b0;
    int               failures     = 0;
    int               pending_cnt  = 0;

    assign o_fail_count = failures;
    assign o_pending    = pending_cnt;

    function automatic int pair_cost();
        int row [MAX_LEN+1];
        int diag;
        int up;
        int best;
        int sub_cost;
        int i;
        int j;
        for (j = 0; j <= second_len; j++)
            row[j] = j;
        for (i = 1; i <= first_len; i++) begin
            diag   = row[0];
            row[0] = i;
            for (j = 1; j <= second_len; j++) begin
                up       = row[j];
                sub_cost = (first_syms[i-1] == second_syms[j-1]) ? 0 : 1;
                best     = up + 1;
                if (row[j-1] + 1 < best)
                    best = row[j-1] + 1;
                if (diag + sub_cost < best)
                    best = diag + sub_cost;
                row[j] = best;
                diag   = up;
            end
        end
        return row[second_len];
    endfunction

    task automatic log_failure(input string what, input t_ced_result want,
                               input t_ced_result got);
        failures++;
        if (failures <= MAX_REPORTS)
            $display("%0t: %s: expected distance %0d too_long %0d, got distance %0d too_long %0d",
                     $time, what, want.distance, want.too_long, got.distance, got.too_long);
    endtask

    always @(posedge i_clk) begin
        t_ced_result want;
        t_ced_result got;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                got.distance = i_distance;
                got.too_long = i_too_long;
                if (awaited_distances.size() == 0) begin
                    want = '0;
                    log_failure("result beat with nothing awaited", want, got);
                end else begin
                    want = awaited_distances.pop_front();
                    if (got.distance !== want.distance || got.too_long !== want.too_long)
                        log_failure("result mismatch", want, got);
                end
            end
            if (i_in_valid && i_in_ready) begin
                case (i_action)
                    ACT_APPEND_FIRST: begin
                        if (first_len < MAX_LEN) begin
                            first_syms[first_len] = i_symbol;
                            first_len++;
                        end else begin
                            first_ovf = 1'b1;
                        end
                    end
                    ACT_APPEND_SECOND: begin
                        if (second_len < MAX_LEN) begin
                            second_syms[second_len] = i_symbol;
                            second_len++;
                        end else begin
                            second_ovf = 1'b1;
                        end
                    end
                    ACT_COMPARE: begin
                        if (first_ovf || second_ovf) begin
                            want.distance = TOO_LONG_CODE;
                            want.too_long = 1'b1;
                        end else begin
                            want.distance = DIST_W'(pair_cost());
                            want.too_long = 1'b0;
                        end
                        awaited_distances.push_back(want);
                        first_len  = 0;
                        second_len = 0;
                        first_ovf  = 1'b0;
                        second_ovf = 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            pending_cnt <= awaited_distances.size();
        end
    end

endmodule

[tb/testbench.sv]
// Testbench top for the capped edit distance block: clock, reset, stimulus and verdict.
module testbench;
    import ced_pkg::*;

    localparam int MAX_LEN     = 24;
    localparam int HALF_PERIOD = 4;
    localparam int HOLD_CYCLES = 600;
    localparam int LIMIT       = 1000000;
    localparam int DRAIN_WAIT  = 2 * MAX_LEN * MAX_LEN + 16;

    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [ACT_W-1:0]  i_action;
    logic [SYM_W-1:0]  i_symbol;
    logic              o_valid;
    logic              i_ready;
    logic [DIST_W-1:0] o_distance;
    logic              o_too_long;

    int          fail_count;
    int          pending_results;
    int          items_sent     = 0;
    int          send_idle_pct  = 0;
    int          stall_pct      = 0;
    int          hold_requests  = 0;
    int          holds_served   = 0;
    int unsigned cycle_count    = 0;

    int send_idle_tbl [4] = '{0, 87, 0, 36};
    int stall_tbl     [4] = '{0, 0, 87, 36};

    always #(HALF_PERIOD) i_clk = ~i_clk;

    capped_edit_distance_top #(.MAX_LEN(MAX_LEN)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_action   (i_action),
        .i_symbol   (i_symbol),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_distance (o_distance),
        .o_too_long (o_too_long)
    );

    ced_scoreboard #(.MAX_LEN(MAX_LEN)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_action     (i_action),
        .i_symbol     (i_symbol),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_distance   (o_distance),
        .i_too_long   (o_too_long),
        .o_fail_count (fail_count),
        .o_pending    (pending_results)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (holds_served != hold_requests) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
                holds_served++;
            end else begin
                i_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic send_beat(input logic [ACT_W-1:0] act, input logic [SYM_W-1:0] sym);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid  <= 1'b1;
        i_action <= act;
        i_symbol <= sym;
        do @(posedge i_clk); while (!o_ready);
        if (act != ACT_UNUSED)
            items_sent++;
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results != 0);
    endtask

    function automatic int pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 80)
            return $urandom_range(6);
        else if (r < 93)
            return $urandom_range(16, 7);
        else if (r < 98)
            return $urandom_range(MAX_LEN, 17);
        return $urandom_range(MAX_LEN + 3, MAX_LEN + 1);
    endfunction

    // style 0: full-range bytes, 1: four-letter alphabet, 2: second string edited from first
    task automatic send_pair(input int len_a, input int len_b, input int style);
        logic [SYM_W-1:0] a_syms[$];
        logic [SYM_W-1:0] b_syms[$];
        logic [SYM_W-1:0] sym;
        int               k;
        int               pos;
        int               ia;
        int               ib;
        for (k = 0; k < len_a; k++) begin
            sym = (style == 1) ? SYM_W'($urandom_range(3)) : SYM_W'($urandom_range(255));
            a_syms.push_back(sym);
        end
        if (style == 2) begin
            b_syms = a_syms;
            repeat ($urandom_range(3)) begin
                pos = $urandom_range(b_syms.size());
                sym = SYM_W'($urandom_range(255));
                case ($urandom_range(2))
                    0: b_syms.insert(pos, sym);
                    1: if (pos < b_syms.size()) b_syms.delete(pos);
                    default: if (pos < b_syms.size()) b_syms[pos] = ~b_syms[pos];
                endcase
            end
        end else begin
            for (k = 0; k < len_b; k++) begin
                sym = (style == 1) ? SYM_W'($urandom_range(3)) : SYM_W'($urandom_range(255));
                b_syms.push_back(sym);
            end
        end
        ia = 0;
        ib = 0;
        while (ia < a_syms.size() || ib < b_syms.size()) begin
            if ($urandom_range(99) < 4)
                send_beat(ACT_UNUSED, SYM_W'($urandom_range(255)));
            if (ib >= b_syms.size() || (ia < a_syms.size() && $urandom_range(1) == 0)) begin
                send_beat(ACT_APPEND_FIRST, a_syms[ia]);
                ia++;
            end else begin
                send_beat(ACT_APPEND_SECOND, b_syms[ib]);
                ib++;
            end
        end
        send_beat(ACT_COMPARE, SYM_W'($urandom_range(255)));
    endtask

    initial begin
        int phase;
        i_rst_n  <= 1'b0;
        i_valid  <= 1'b0;
        i_action <= ACT_APPEND_FIRST;
        i_symbol <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_beat(ACT_COMPARE, 8'hFF);
        send_beat(ACT_APPEND_FIRST, 8'h00);
        send_beat(ACT_COMPARE, 8'h00);
        send_beat(ACT_APPEND_SECOND, 8'hFF);
        send_beat(ACT_APPEND_SECOND, 8'h00);
        send_beat(ACT_COMPARE, 8'h5A);
        send_beat(ACT_APPEND_FIRST, 8'hFF);
        send_beat(ACT_APPEND_SECOND, 8'hFF);
        send_beat(ACT_COMPARE, 8'hA5);
        send_beat(ACT_APPEND_FIRST, 8'h55);
        send_beat(ACT_UNUSED, 8'hAA);
        send_beat(ACT_APPEND_SECOND, 8'hAA);
        send_beat(ACT_COMPARE, 8'h00);
        send_beat(ACT_APPEND_FIRST, 8'h01);
        send_beat(ACT_APPEND_FIRST, 8'h02);
        send_beat(ACT_APPEND_SECOND, 8'h02);
        send_beat(ACT_APPEND_SECOND, 8'h01);
        send_beat(ACT_COMPARE, 8'h00);
        send_beat(ACT_APPEND_FIRST, 8'h80);
        send_beat(ACT_APPEND_FIRST, 8'h7F);
        send_beat(ACT_APPEND_FIRST, 8'h80);
        send_beat(ACT_APPEND_SECOND, 8'h7F);
        send_beat(ACT_APPEND_SECOND, 8'h80);
        send_beat(ACT_COMPARE, 8'hFF);
        wait_for_results();

        for (phase = 0; phase < 4; phase++) begin
            send_idle_pct = send_idle_tbl[phase];
            stall_pct     = stall_tbl[phase];
            if (phase == 0) begin
                hold_requests++;
                send_pair(MAX_LEN + 1, 3, 0);
                send_pair(2, MAX_LEN + 2, 1);
                send_pair(MAX_LEN, MAX_LEN, 2);
                send_pair(MAX_LEN, MAX_LEN, 0);
                send_pair(MAX_LEN + 2, MAX_LEN + 2, 0);
                send_beat(ACT_COMPARE, 8'h00);
            end
            while (items_sent < 25 + (phase + 1) * 330) begin
                send_pair(pick_length(), pick_length(), $urandom_range(2));
                if ($urandom_range(99) < 6)
                    send_beat(ACT_COMPARE, SYM_W'($urandom_range(255)));
            end
            wait_for_results();
        end

        stall_pct = 0;
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0 && pending_results == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
